// File: rtl/bd5_pkg.sv
// Shared constants, types and helpers of the 5x5 Bayer demosaic block.
`timescale 1ns / 1ps
package bd5_pkg;

  localparam int SW = 11;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam logic [SW-1:0] RESET_SIZE = 11'd1024;
  localparam logic [12:0] MIN_SIZE = 13'd6;
  localparam int OUT_DEPTH = 8;
  localparam int PW = 13;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic odd_r;
    logic odd_c;
    logic is_border;
    logic is_last;
  } meta_t;

  typedef struct packed {
    logic [12:0] red;
    logic [12:0] green;
    logic [12:0] blue;
    logic        border;
    logic        last;
  } result_t;

  function automatic logic [SW-1:0] fit_size(logic [SW-1:0] v, logic [12:0] maxv);
    logic [12:0] s;
    s = ({2'b00, v} > maxv) ? maxv : {2'b00, v};
    if (s < MIN_SIZE) s = MIN_SIZE;
    s[0] = 1'b0;
    if (s < MIN_SIZE) s = MIN_SIZE;
    return s[SW-1:0];
  endfunction

  function automatic logic [12:0] clamp13(logic signed [15:0] v);
    return v[15] ? 13'd0 : v[12:0];
  endfunction

endpackage

// File: rtl/bayer_demosaic_5x5.sv
// Top level of the 5x5 Bayer demosaic block: line store, window, kernels, output queue.
`timescale 1ns / 1ps
// Takes one RGGB byte per clock in raster order while in_ready is high (no configuration write
// or recompute under way and a free output queue slot), and returns the full color of the pixel
// two rows and two columns back, one result per clock when the output side keeps up. The
// rate is set by the line store, one 32-bit word per column holding the four previous lines,
// read when a request is taken and written back the next cycle with forwarding between neighbors.
// The input holds during a configuration write and after it while a restoring divider reduces
// the current column positions modulo the new width. Flush requests drain the last results.
module bayer_demosaic_5x5 #(
  parameter int MAX_WIDTH = bd5_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bd5_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] red,
  output logic [12:0] green,
  output logic [12:0] blue,
  output logic        border,
  output logic        last
);

  localparam int SW = bd5_pkg::SW;
  localparam int PW = bd5_pkg::PW;
  localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DEPTH = bd5_pkg::OUT_DEPTH;
  localparam int QB = $clog2(DEPTH);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);
  localparam logic [PW-1:0] PMAX = {PW{1'b1}};

  logic [SW-1:0] fw, fh;
  logic [SW-1:0] in_row, in_col, out_row, out_col, in_mod, out_mod;
  logic [PW-1:0] pend;
  logic          busy;
  logic [3:0]    step;
  logic [QB:0]   used;

  logic [31:0] mem [MAX_WIDTH];
  logic [31:0] rdata;
  logic [7:0]  win [5][5];

  logic             s1_valid, s1_emit;
  logic [SW-1:0]    s1_col;
  logic [7:0]       s1_pix;
  bd5_pkg::meta_t   s1_meta;
  logic             wq_valid;
  logic [SW-1:0]    wq_col;
  logic [31:0]      wq_data;

  logic             s2_valid;
  bd5_pkg::meta_t   s2_meta;
  logic             s3_valid;
  bd5_pkg::meta_t   s3_meta;
  logic [8:0]       s3_a, s3_b, s3_dv, s3_dh;
  logic [9:0]       s3_cr;
  logic [7:0]       s3_ctr;

  bd5_pkg::result_t fifo [DEPTH];
  logic [QB-1:0]    wr_ptr, rd_ptr;
  logic [QB:0]      count;

  logic accept, is_flush, do_shift, do_emit, push, pop;
  logic [PW-1:0] pend_inc, thr;
  logic [SW-1:0] col_sel, in_mod_next, out_mod_next;
  logic [7:0]    pix_sel;
  logic          in_wrap, out_wrap;
  bd5_pkg::meta_t meta_now;
  logic [31:0]   word, word_new;
  logic [7:0]    cin [5];
  logic [21:0]   div_sh;
  bd5_pkg::result_t res;
  logic signed [15:0] k_g, k_h, k_v, k_d, nat;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && !cfg_valid && (used < (QB+1)'(DEPTH));
  assign accept = in_valid && in_ready;
  assign is_flush = (op == bd5_pkg::OP_FLUSH);
  assign pend_inc = (pend == PMAX) ? pend : pend + 1'b1;
  assign thr = PW'({fw, 1'b0}) + PW'(2);
  assign do_shift = accept && (!is_flush || pend != '0);
  assign do_emit = accept && (is_flush ? (pend != '0) : (pend_inc > thr));
  assign col_sel = is_flush ? out_mod : in_mod;
  assign pix_sel = is_flush ? 8'd0 : pixel;
  assign in_wrap = ({1'b0, in_col} + 12'd1) >= {1'b0, fw};
  assign out_wrap = ({1'b0, out_col} + 12'd1) >= {1'b0, fw};
  assign in_mod_next = in_wrap ? '0 : ((in_mod + 1'b1 == fw) ? '0 : in_mod + 1'b1);
  assign out_mod_next = out_wrap ? SW'(2) : ((out_mod + 1'b1 == fw) ? '0 : out_mod + 1'b1);
  assign div_sh = 22'(fw) << step;

  always_comb begin
    meta_now.odd_r = out_row[0];
    meta_now.odd_c = out_col[0];
    meta_now.is_border = (out_row < SW'(2)) || (out_col < SW'(2)) ||
                         (({1'b0, out_row} + 12'd2) >= {1'b0, fh}) ||
                         (({1'b0, out_col} + 12'd2) >= {1'b0, fw});
    meta_now.is_last = (({1'b0, out_row} + 12'd1) == {1'b0, fh}) &&
                       (({1'b0, out_col} + 12'd1) == {1'b0, fw});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= bd5_pkg::fit_size(bd5_pkg::RESET_SIZE, MAXW);
      fh <= bd5_pkg::fit_size(bd5_pkg::RESET_SIZE, MAXH);
      in_row <= '0;
      in_col <= '0;
      out_row <= '0;
      out_col <= '0;
      in_mod <= '0;
      out_mod <= SW'(2);
      pend <= '0;
      busy <= 1'b0;
      step <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bd5_pkg::REG_FRAME_WIDTH) fw <= bd5_pkg::fit_size(cfg_data, MAXW);
      if (cfg_index == bd5_pkg::REG_FRAME_HEIGHT) fh <= bd5_pkg::fit_size(cfg_data, MAXH);
      in_mod <= in_col;
      out_mod <= out_col + SW'(2);
      step <= 4'(SW - 1);
      busy <= 1'b1;
    end else if (busy) begin
      if (22'(in_mod) >= div_sh) in_mod <= in_mod - div_sh[SW-1:0];
      if (22'(out_mod) >= div_sh) out_mod <= out_mod - div_sh[SW-1:0];
      if (step == '0) busy <= 1'b0;
      else step <= step - 1'b1;
    end else if (accept) begin
      if (!is_flush) begin
        in_col <= in_wrap ? '0 : in_col + 1'b1;
        if (in_wrap) in_row <= (({1'b0, in_row} + 12'd1) >= {1'b0, fh}) ? '0 : in_row + 1'b1;
        in_mod <= in_mod_next;
        pend <= do_emit ? pend_inc - 1'b1 : pend_inc;
      end else if (pend != '0) begin
        pend <= pend - 1'b1;
      end
      if (do_emit) begin
        out_col <= out_wrap ? '0 : out_col + 1'b1;
        if (out_wrap) begin
          out_row <= (({1'b0, out_row} + 12'd1) >= {1'b0, fh}) ? '0 : out_row + 1'b1;
        end
        out_mod <= out_mod_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wq_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= do_shift;
      wq_valid <= s1_valid;
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      rdata <= mem[CB'(col_sel)];
      s1_emit <= do_emit;
      s1_col <= col_sel;
      s1_pix <= pix_sel;
      s1_meta <= meta_now;
    end
    if (s1_valid) mem[CB'(s1_col)] <= word_new;
    wq_col <= s1_col;
    wq_data <= word_new;
    s2_meta <= s1_meta;
    s3_meta <= s2_meta;
  end

  always_comb begin
    word = (wq_valid && wq_col == s1_col) ? wq_data : rdata;
    for (int k = 0; k < 4; k++) cin[k] = word[8*k +: 8];
    cin[4] = s1_pix;
    for (int k = 0; k < 4; k++) word_new[8*k +: 8] = cin[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 5; c++) win[r][c] <= 8'd0;
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) win[r][c] <= win[r][c+1];
        win[r][4] <= cin[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_a <= 9'(win[0][2]) + 9'(win[4][2]);
    s3_b <= 9'(win[2][0]) + 9'(win[2][4]);
    s3_cr <= 10'(win[1][1]) + 10'(win[1][3]) + 10'(win[3][1]) + 10'(win[3][3]);
    s3_dv <= 9'(win[1][2]) + 9'(win[3][2]);
    s3_dh <= 9'(win[2][1]) + 9'(win[2][3]);
    s3_ctr <= win[2][2];
  end

  always_comb begin
    logic signed [15:0] a, b, cr, dv, dh, ct;
    a = $signed(16'(s3_a));
    b = $signed(16'(s3_b));
    cr = $signed(16'(s3_cr));
    dv = $signed(16'(s3_dv));
    dh = $signed(16'(s3_dh));
    ct = $signed(16'(s3_ctr));
    k_g = 16'sd4 * (dv + dh) + 16'sd8 * ct - 16'sd2 * (a + b);
    k_h = a + 16'sd8 * dh + 16'sd10 * ct - 16'sd2 * cr - 16'sd2 * b;
    k_v = b + 16'sd8 * dv + 16'sd10 * ct - 16'sd2 * cr - 16'sd2 * a;
    k_d = 16'sd4 * cr + 16'sd12 * ct - 16'sd3 * (a + b);
    nat = 16'sd16 * ct;
    res = '0;
    res.border = s3_meta.is_border;
    res.last = s3_meta.is_last;
    case ({s3_meta.odd_r, s3_meta.odd_c})
      2'b00: begin
        res.red = nat[12:0];
        if (!s3_meta.is_border) begin
          res.green = bd5_pkg::clamp13(k_g);
          res.blue = bd5_pkg::clamp13(k_d);
        end
      end
      2'b01: begin
        res.green = nat[12:0];
        if (!s3_meta.is_border) begin
          res.red = bd5_pkg::clamp13(k_h);
          res.blue = bd5_pkg::clamp13(k_v);
        end
      end
      2'b10: begin
        res.green = nat[12:0];
        if (!s3_meta.is_border) begin
          res.red = bd5_pkg::clamp13(k_v);
          res.blue = bd5_pkg::clamp13(k_h);
        end
      end
      default: begin
        res.blue = nat[12:0];
        if (!s3_meta.is_border) begin
          res.red = bd5_pkg::clamp13(k_d);
          res.green = bd5_pkg::clamp13(k_g);
        end
      end
    endcase
  end

  assign push = s3_valid;
  assign pop = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign red = fifo[rd_ptr].red;
  assign green = fifo[rd_ptr].green;
  assign blue = fifo[rd_ptr].blue;
  assign border = fifo[rd_ptr].border;
  assign last = fifo[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      used <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QB+1)'(push) - (QB+1)'(pop);
      used <= used + (QB+1)'(do_emit) - (QB+1)'(pop);
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (QB+1)'(DEPTH))
    else $error("output credit count exceeds queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == (QB+1)'(DEPTH)))
    else $error("output queue overflow");

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("input taken during column recompute");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    count <= used)
    else $error("queued results exceed outstanding credits");

endmodule

// File: bench/tb_bayer_demosaic_5x5.sv
// Self-checking bench for bayer_demosaic_5x5: directed table, random frames, color predictor.
`timescale 1ns / 1ps
module tb_bayer_demosaic_5x5;

  localparam int LINE_MAX = 1024;

  localparam int K_GREEN [5][5] = '{'{0, 0, -2, 0, 0}, '{0, 0, 4, 0, 0}, '{-2, 4, 8, 4, -2},
                                    '{0, 0, 4, 0, 0}, '{0, 0, -2, 0, 0}};
  localparam int K_HORIZ [5][5] = '{'{0, 0, 1, 0, 0}, '{0, -2, 0, -2, 0}, '{-2, 8, 10, 8, -2},
                                    '{0, -2, 0, -2, 0}, '{0, 0, 1, 0, 0}};
  localparam int K_VERT [5][5] = '{'{0, 0, -2, 0, 0}, '{0, -2, 8, -2, 0}, '{1, 0, 10, 0, 1},
                                   '{0, -2, 8, -2, 0}, '{0, 0, -2, 0, 0}};
  localparam int K_DIAG [5][5] = '{'{0, 0, -3, 0, 0}, '{0, 4, 0, 4, 0}, '{-3, 0, 12, 0, -3},
                                   '{0, 4, 0, 4, 0}, '{0, 0, -3, 0, 0}};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  pixel;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [12:0] red;
  logic [12:0] green;
  logic [12:0] blue;
  logic        border;
  logic        last;

  bayer_demosaic_5x5 u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel(pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue), .border(border), .last(last)
  );

  // predictor state
  logic [7:0] line_mem [4][LINE_MAX];
  logic [7:0] win [5][5];
  int unsigned in_r, in_c, out_r, out_c, backlog, fw, fh;

  bd5_pkg::result_t color_q[$];
  int      mismatches;
  int      results_seen;
  bit      quiet;

  typedef struct {
    logic             op;
    logic [7:0]       pix;
    int               n;
    bit               typed;
    bd5_pkg::result_t res;
  } stim_row_t;

  function automatic int unsigned fit_dim(int unsigned v);
    int unsigned s;
    s = (v > LINE_MAX) ? LINE_MAX : v;
    if (s < 6) s = 6;
    s = s & ~32'd1;
    return s;
  endfunction

  function automatic void step_pos(inout int unsigned r, inout int unsigned c);
    c++;
    if (c >= fw) begin
      c = 0;
      r++;
      if (r >= fh) r = 0;
    end
  endfunction

  function automatic void shift_col(int unsigned col, logic [7:0] pix);
    logic [7:0] colv [5];
    if (col >= LINE_MAX) col = 0;
    for (int k = 0; k < 4; k++) colv[k] = line_mem[k][col];
    colv[4] = pix;
    for (int k = 0; k < 4; k++) line_mem[k][col] = colv[k + 1];
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
      win[r][4] = colv[r];
    end
  endfunction

  function automatic logic [12:0] kernel_sum(int kern [5][5]);
    int s;
    s = 0;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) s += kern[r][c] * int'(win[r][c]);
    return (s < 0) ? 13'd0 : s[12:0];
  endfunction

  function automatic bd5_pkg::result_t interp_pixel();
    bd5_pkg::result_t o;
    logic [12:0]      nat;
    bit               edg;
    nat = {1'b0, win[2][2], 4'b0};
    edg = (out_r < 2) || (out_r + 2 >= fh) || (out_c < 2) || (out_c + 2 >= fw);
    o = '0;
    case ({out_r[0], out_c[0]})
      2'b00: begin
        o.red = nat;
        if (!edg) begin o.green = kernel_sum(K_GREEN); o.blue = kernel_sum(K_DIAG); end
      end
      2'b01: begin
        o.green = nat;
        if (!edg) begin o.red = kernel_sum(K_HORIZ); o.blue = kernel_sum(K_VERT); end
      end
      2'b10: begin
        o.green = nat;
        if (!edg) begin o.red = kernel_sum(K_VERT); o.blue = kernel_sum(K_HORIZ); end
      end
      default: begin
        o.blue = nat;
        if (!edg) begin o.red = kernel_sum(K_DIAG); o.green = kernel_sum(K_GREEN); end
      end
    endcase
    o.border = edg;
    o.last = (out_r + 1 == fh) && (out_c + 1 == fw);
    step_pos(out_r, out_c);
    if (backlog > 0) backlog--;
    return o;
  endfunction

  function automatic bit predict_color(logic o_op, logic [7:0] pix,
                                       output bd5_pkg::result_t o);
    o = '0;
    if (o_op == bd5_pkg::OP_PIXEL) begin
      shift_col(in_c % fw, pix);
      step_pos(in_r, in_c);
      backlog++;
      if (backlog > 2 * fw + 2) begin
        o = interp_pixel();
        return 1;
      end
      return 0;
    end
    if (backlog == 0) return 0;
    shift_col((out_c + 2) % fw, 8'd0);
    o = interp_pixel();
    return 1;
  endfunction

  task automatic idle_burst();
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        op <= 1'($urandom_range(0, 1));
        pixel <= 8'($urandom_range(0, 255));
      end
    end
  endtask

  task automatic send_request(logic o_op, logic [7:0] pix, bit typed,
                              bd5_pkg::result_t typed_res);
    bd5_pkg::result_t exp_res;
    bit               has;
    idle_burst();
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o_op;
    pixel <= pix;
    do @(posedge clk); while (!in_ready);
    has = predict_color(o_op, pix, exp_res);
    if (has) color_q.push_back(typed ? typed_res : exp_res);
  endtask

  task automatic send_pixel(logic [7:0] pix);
    send_request(bd5_pkg::OP_PIXEL, pix, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == bd5_pkg::REG_FRAME_WIDTH) fw = fit_dim(val);
    else if (idx == bd5_pkg::REG_FRAME_HEIGHT) fh = fit_dim(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= 11'($urandom_range(0, 2047));
  endtask

  task automatic drain_frames();
    while (backlog > 0)
      send_request(bd5_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic run_phase(logic [10:0] w_raw, logic [10:0] h_raw, int frames);
    write_reg(bd5_pkg::REG_FRAME_WIDTH, w_raw);
    write_reg(bd5_pkg::REG_FRAME_HEIGHT, h_raw);
    for (int f = 0; f < frames; f++) begin
      for (int i = 0; i < fw * fh; i++) begin
        if (f > 0 && $urandom_range(0, 99) == 0)
          send_request(bd5_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
        case ($urandom_range(0, 9))
          0: send_pixel(8'd0);
          1: send_pixel(8'd255);
          default: send_pixel(8'($urandom_range(0, 255)));
        endcase
      end
    end
    drain_frames();
    if ($urandom_range(0, 1) == 0) send_request(bd5_pkg::OP_FLUSH, 8'd0, 1'b0, '0);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("bayer_demosaic_5x5 test failed");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    bd5_pkg::result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{red: red, green: green, blue: blue, border: border, last: last};
      results_seen++;
      if (color_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = color_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // output side stalls, with one long hold
  initial begin
    int  gap;
    bit  held;
    held = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_seen >= 100) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    dir_rows = '{
      '{bd5_pkg::OP_FLUSH, 8'd0,   1,  1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd255, 14, 1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd255, 1,  1'b1, '{red: 13'd4080, green: 13'd0, blue: 13'd0,
                                               border: 1'b1, last: 1'b0}},
      '{bd5_pkg::OP_PIXEL, 8'd0,   5,  1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd255, 7,  1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd0,   3,  1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd170, 3,  1'b0, '0},
      '{bd5_pkg::OP_PIXEL, 8'd85,  3,  1'b0, '0},
      '{bd5_pkg::OP_FLUSH, 8'd255, 14, 1'b0, '0},
      '{bd5_pkg::OP_FLUSH, 8'd0,   1,  1'b0, '0}
    };
    mismatches = 0;
    results_seen = 0;
    quiet = 0;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0; backlog = 0;
    fw = fit_dim(1024);
    fh = fit_dim(1024);
    for (int r = 0; r < 5; r++) for (int c = 0; c < 5; c++) win[r][c] = 8'd0;
    for (int k = 0; k < 4; k++) for (int c = 0; c < LINE_MAX; c++) line_mem[k][c] = 8'd0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = bd5_pkg::OP_PIXEL;
    pixel = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = bd5_pkg::REG_FRAME_WIDTH;
    cfg_data = 11'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(bd5_pkg::REG_FRAME_WIDTH, 11'd6);
    write_reg(bd5_pkg::REG_FRAME_HEIGHT, 11'd6);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      for (int j = 0; j < row.n; j++) send_request(row.op, row.pix, row.typed, row.res);
    end
    wait_drained();

    run_phase(11'd0, 11'd7, 2);
    run_phase(11'd9, 11'd13, 1);
    for (int p = 0; p < 3; p++)
      run_phase(11'($urandom_range(0, 14)), 11'($urandom_range(0, 14)), 1);
    quiet = 1;
    run_phase(11'd12, 11'd8, 1);

    if (mismatches == 0) begin
      $display("bayer_demosaic_5x5 test passed");
    end else begin
      $display("bayer_demosaic_5x5 test failed");
    end
    $finish;
  end

endmodule

// File: bayer_demosaic_5x5.f
rtl/bd5_pkg.sv
rtl/bayer_demosaic_5x5.sv
bench/tb_bayer_demosaic_5x5.sv
